[hw/rtl/pfa_pkg.sv]
// Shared types, constants and helpers for the partition fit allocator.
// No dependencies; every other file of the block imports this package.
package pfa_pkg;

	localparam int SLOT_COUNT = 16;
	localparam int IDX_W      = $clog2(SLOT_COUNT);
	localparam int SIZE_W     = 5;
	localparam int OWNER_W    = 16;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	typedef enum logic [1:0] {
		OP_ALLOC    = 2'd0,
		OP_RELEASE  = 2'd1,
		OP_COALESCE = 2'd2,
		OP_QUERY    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY
	} state_t;

	typedef enum logic {
		PASS_SCAN,
		PASS_APPLY
	} pass_t;

	typedef struct packed {
		op_t                opcode;
		logic [SIZE_W-1:0]  request_size;
		logic [OWNER_W-1:0] owner_id;
	} cmd_t;

	typedef struct packed {
		logic              status;
		logic [3:0]        slot_index;
		logic [SIZE_W-1:0] total_free;
		logic [SIZE_W-1:0] largest_free;
	} result_t;

	typedef struct packed {
		logic               free;
		logic [SIZE_W-1:0]  size;
		logic [OWNER_W-1:0] owner;
	} slot_t;

	typedef struct packed {
		logic             active;
		logic             clr;
		pass_t            pass;
		logic [1:0]       mode;
		logic [IDX_W-1:0] idx;
		logic             peek_free;
	} head_ctl_t;

	function automatic logic [SIZE_W-1:0] sat_add(input logic [SIZE_W-1:0] a,
		input logic [SIZE_W-1:0] b);
		logic [SIZE_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SIZE_W] ? {SIZE_W{1'b1}} : s[SIZE_W-1:0];
	endfunction

endpackage

[hw/rtl/pfa_cell.sv]
// One slot of the partition ring: holds free mark, size and owner.
// Depends on pfa_pkg for slot_t.
module pfa_cell
	import pfa_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift,
	input  slot_t d,
	output slot_t q
);

	slot_t slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q.free  <= 1'b1;
			slot_q.size  <= SIZE_W'(1);
			slot_q.owner <= '0;
		end else if (shift) begin
			slot_q <= d;
		end
	end

	assign q = slot_q;

endmodule

[hw/rtl/pfa_head.sv]
// Head of the partition ring: applies the operation to the slot leaving the
// ring, tracks the fit candidate, run sum and statistics. Depends on pfa_pkg.
module pfa_head
	import pfa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  head_ctl_t ctl,
	input  cmd_t      cmd,
	input  slot_t     slot_in,
	output slot_t     slot_out,
	output result_t   res
);

	logic [SIZE_W-1:0] acc_q, tot_q, big_q, gap_q;
	logic              found_q;
	logic [IDX_W-1:0]  cand_q;

	logic [SIZE_W-1:0] acc_n, run_sum, gap, tot_n, big_n;
	logic              fits, take;

	always_comb begin
		slot_out = slot_in;
		acc_n    = acc_q;
		run_sum  = sat_add(acc_q, slot_in.size);
		fits     = slot_in.free && (slot_in.size >= cmd.request_size);
		gap      = slot_in.size - cmd.request_size;
		if (ctl.mode == FIT_BEST)
			take = fits && (!found_q || gap <= gap_q);
		else if (ctl.mode == FIT_WORST)
			take = fits && (!found_q || gap >= gap_q);
		else
			take = fits;
		if (ctl.pass == PASS_APPLY) begin
			case (cmd.opcode)
				OP_ALLOC: begin
					if (found_q && ctl.idx == cand_q) begin
						slot_out.free  = 1'b0;
						slot_out.owner = cmd.owner_id;
					end
				end
				OP_RELEASE: begin
					if (!slot_in.free && slot_in.owner == cmd.owner_id) begin
						slot_out.free  = 1'b1;
						slot_out.owner = '0;
					end
				end
				OP_COALESCE: begin
					if (slot_in.free) begin
						if (ctl.idx == '0 || !ctl.peek_free) begin
							slot_out.size = run_sum;
							acc_n         = '0;
						end else begin
							slot_out.size = '0;
							acc_n         = run_sum;
						end
					end
				end
				default: ;
			endcase
		end
		tot_n = tot_q;
		big_n = big_q;
		if (slot_out.free) begin
			tot_n = sat_add(tot_q, slot_out.size);
			if (slot_out.size > big_q)
				big_n = slot_out.size;
		end
		res.status       = (cmd.opcode == OP_ALLOC) && !found_q;
		res.slot_index   = (cmd.opcode == OP_ALLOC && found_q) ? 4'(cand_q) : 4'd0;
		res.total_free   = tot_n;
		res.largest_free = big_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			tot_q   <= '0;
			big_q   <= '0;
			gap_q   <= '0;
			found_q <= 1'b0;
			cand_q  <= '0;
		end else if (ctl.clr) begin
			acc_q   <= '0;
			tot_q   <= '0;
			big_q   <= '0;
			gap_q   <= '0;
			found_q <= 1'b0;
			cand_q  <= '0;
		end else if (ctl.active) begin
			if (ctl.pass == PASS_SCAN) begin
				if (take) begin
					found_q <= 1'b1;
					cand_q  <= ctl.idx;
					gap_q   <= gap;
				end
			end else begin
				acc_q <= acc_n;
				tot_q <= tot_n;
				big_q <= big_n;
			end
		end
	end

endmodule

[hw/rtl/partition_fit_allocator.sv]
// Top level of the partition fit allocator: command handshake, sequencer and
// the ring of slot cells. Depends on pfa_pkg, pfa_cell and pfa_head.
//
//   port          dir  beat
//   start/cmd     in   command accepted when start is high and busy is low
//   done/result   out  one result per command, valid for one cycle
//   cfg_we/wdata  in   fit mode written whenever cfg_we is high
//
// Query, release and coalesce make a single pass, allocate makes two: the
// slots circulate once through the head per pass, highest index first, and
// allocate needs a search pass before the marking pass.
// done rises the cycle after the last pass; a new command may start then.
// Reset leaves every slot free with size one and the fit mode at first fit.
// The receiver cannot stall; results are held until the next beat.
module partition_fit_allocator
	import pfa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  cmd_t       cmd,
	output logic       done,
	output result_t    result,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata
);

	state_t            state_q, state_n;
	logic [IDX_W-1:0]  cnt_q, cnt_n;
	cmd_t              cmd_q;
	logic [1:0]        fit_mode_q;
	logic              done_q, done_n;
	result_t           result_q;
	logic              accept, shift;
	head_ctl_t         ctl;
	slot_t             ring [SLOT_COUNT];
	slot_t             head_out;
	result_t           head_res;

	assign accept = start && (state_q == ST_IDLE);
	assign shift  = (state_q == ST_SCAN) || (state_q == ST_APPLY);

	always_comb begin
		state_n = state_q;
		cnt_n   = cnt_q;
		done_n  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cnt_n = IDX_W'(SLOT_COUNT - 1);
				if (start)
					state_n = (cmd.opcode == OP_ALLOC) ? ST_SCAN : ST_APPLY;
			end
			ST_SCAN: begin
				cnt_n = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					state_n = ST_APPLY;
					cnt_n   = IDX_W'(SLOT_COUNT - 1);
				end
			end
			ST_APPLY: begin
				cnt_n = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					state_n = ST_IDLE;
					cnt_n   = IDX_W'(SLOT_COUNT - 1);
					done_n  = 1'b1;
				end
			end
			default: begin
				state_n = ST_IDLE;
				cnt_n   = IDX_W'(SLOT_COUNT - 1);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= IDX_W'(SLOT_COUNT - 1);
			done_q     <= 1'b0;
			fit_mode_q <= FIT_FIRST;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
			done_q  <= done_n;
			if (cfg_we)
				fit_mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			cmd_q <= cmd;
		if (done_n)
			result_q <= head_res;
	end

	assign ctl.active    = shift;
	assign ctl.clr       = accept;
	assign ctl.pass      = (state_q == ST_SCAN) ? PASS_SCAN : PASS_APPLY;
	assign ctl.mode      = fit_mode_q;
	assign ctl.idx       = cnt_q;
	assign ctl.peek_free = ring[SLOT_COUNT-2].free;

	pfa_head u_head (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.cmd      (cmd_q),
		.slot_in  (ring[SLOT_COUNT-1]),
		.slot_out (head_out),
		.res      (head_res)
	);

	for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
		pfa_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.d      ((k == 0) ? head_out : ring[(k == 0) ? 0 : k-1]),
			.q      (ring[k])
		);
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	a_done_after_pass: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_APPLY))
		else $error("result beat without a finishing pass");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("command accepted but sequencer stayed idle");

	a_fail_index: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status |-> result.slot_index == 4'd0)
		else $error("failed allocate reports a slot");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> cnt_q == IDX_W'(SLOT_COUNT - 1))
		else $error("ring position lost while idle");

endmodule
